/* rtl/qurw_pkg.sv */
// Package for the quote update rate window unit: widths, time conversion
// constants, log constants, state encodings and the front-to-back queue entry.
// No dependencies.
`default_nettype none

package qurw_pkg;

   // Field widths
   localparam int TIME_CODE_W = 30;
   localparam int MS_W        = 29;
   localparam int PRICE_W     = 64;
   localparam int SIZE_W      = 32;
   localparam int COUNT_W     = 32;
   localparam int VALUE_W     = 48;
   localparam int WLEN_W      = 32;

   // Stream word layout
   localparam int REQ_DATA_W  = 224;
   localparam int RSP_DATA_W  = 48;

   // Configuration port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LEN = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_LOG_NORM   = CSR_INDEX_W'(1);
   localparam logic [WLEN_W-1:0]      WINDOW_RESET   = WLEN_W'(500);

   // Fixed-point output format
   localparam int FRAC_BITS_DEF = 16;
   localparam int FRAC_BITS_MAX = 24;
   localparam int RAW_W         = COUNT_W + FRAC_BITS_MAX;

   // Time code conversion: mins = code / 100000, hour = code / 10000000,
   // both by reciprocal multiply and one correction step.
   localparam int TC_W       = TIME_CODE_W + 1;
   localparam int MINS_W     = 14;
   localparam int HOUR_W     = 7;
   localparam int RECIP_SH   = 30;
   localparam int MINS_DIV   = 100000;
   localparam int MINS_RECIP = 10737;
   localparam int HOUR_DIV   = 10000000;
   localparam int HOUR_RECIP = 107;
   // ms = code - MIN_GAP * mins - HOUR_GAP * hour
   localparam int MIN_GAP    = 40000;
   localparam int HOUR_GAP   = 2400000;

   // Logarithm unit
   localparam int MANT_W       = 32;
   localparam int EXP_W        = 6;
   localparam int NORM_STEPS   = 5;
   localparam int NORM_FIRST   = 16;
   localparam int STEP_W       = 5;
   localparam int LOG_T_W      = 55;
   localparam logic [MANT_W-1:0] LN2_Q32 = 32'd2977044472;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      TK_NONE,
      TK_FIRST,
      TK_NEXT
   } tick_kind_type;

   typedef struct packed {
      tick_kind_type     kind;
      logic              changed;
      logic [MS_W-1:0]   now_ms;
   } entry_type;

   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] count;
   } log_req_type;

   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] value;
   } log_rsp_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_EST,
      F_FIX,
      F_CONV
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_LOG,
      B_OUT
   } back_state_type;

   typedef enum logic [2:0] {
      L_IDLE,
      L_NORM,
      L_SQR,
      L_MLO,
      L_MHI,
      L_RND
   } log_state_type;

endpackage

`default_nettype wire

/* rtl/qurw_front.sv */
// Front end: accepts request words, classifies the tick against the last
// latched quote and converts the HHMMSSmmm code to milliseconds. Uses qurw_pkg.
`default_nettype none

module qurw_front
   import qurw_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic                   in_tick,
   input  wire logic [TIME_CODE_W-1:0] in_code,
   input  wire logic [PRICE_W-1:0]     in_bid,
   input  wire logic [PRICE_W-1:0]     in_ask,
   input  wire logic [SIZE_W-1:0]      in_bid_size,
   input  wire logic [SIZE_W-1:0]      in_ask_size,
   input  wire logic                   q_full,
   output logic                        q_push,
   output entry_type                   q_entry
);

   front_state_type           state_ff, state_in;
   logic                      seen_ff, seen_in;
   logic [PRICE_W-1:0]        prev_bid_ff, prev_bid_in;
   logic [PRICE_W-1:0]        prev_ask_ff, prev_ask_in;
   logic [SIZE_W-1:0]         prev_bsz_ff, prev_bsz_in;
   logic [SIZE_W-1:0]         prev_asz_ff, prev_asz_in;

   logic                      tick_ff, tick_in;
   logic [TIME_CODE_W-1:0]    code_ff, code_in;
   logic [PRICE_W-1:0]        bid_ff, bid_in;
   logic [PRICE_W-1:0]        ask_ff, ask_in;
   logic [SIZE_W-1:0]         bsz_ff, bsz_in;
   logic [SIZE_W-1:0]         asz_ff, asz_in;
   tick_kind_type             kind_ff, kind_in;
   logic                      changed_ff, changed_in;
   logic [MINS_W-1:0]         mins_ff, mins_in;
   logic [HOUR_W-1:0]         hour_ff, hour_in;

   logic [TIME_CODE_W+MINS_W-1:0] mins_prod;
   logic [TIME_CODE_W+HOUR_W-1:0] hour_prod;
   logic [TC_W-1:0]               mins_rem;
   logic [TC_W-1:0]               hour_rem;
   logic [TC_W-1:0]               ms_wide;
   logic                          quote_diff;

   // Quotient estimates, remainders for the correction, final milliseconds
   assign mins_prod  = (TIME_CODE_W+MINS_W)'(code_ff) * (TIME_CODE_W+MINS_W)'(MINS_RECIP);
   assign hour_prod  = (TIME_CODE_W+HOUR_W)'(code_ff) * (TIME_CODE_W+HOUR_W)'(HOUR_RECIP);
   assign mins_rem   = TC_W'(code_ff) - TC_W'(mins_ff) * TC_W'(MINS_DIV);
   assign hour_rem   = TC_W'(code_ff) - TC_W'(hour_ff) * TC_W'(HOUR_DIV);
   assign ms_wide    = TC_W'(code_ff) - TC_W'(mins_ff) * TC_W'(MIN_GAP)
                       - TC_W'(hour_ff) * TC_W'(HOUR_GAP);
   assign quote_diff = (bid_ff != prev_bid_ff) || (ask_ff != prev_ask_ff) ||
                       (bsz_ff != prev_bsz_ff) || (asz_ff != prev_asz_ff);

   assign q_entry.kind    = kind_ff;
   assign q_entry.changed = changed_ff;
   assign q_entry.now_ms  = ms_wide[MS_W-1:0];

   // Next state and datapath
   always_comb begin
      state_in    = state_ff;
      seen_in     = seen_ff;
      prev_bid_in = prev_bid_ff;
      prev_ask_in = prev_ask_ff;
      prev_bsz_in = prev_bsz_ff;
      prev_asz_in = prev_asz_ff;
      tick_in     = tick_ff;
      code_in     = code_ff;
      bid_in      = bid_ff;
      ask_in      = ask_ff;
      bsz_in      = bsz_ff;
      asz_in      = asz_ff;
      kind_in     = kind_ff;
      changed_in  = changed_ff;
      mins_in     = mins_ff;
      hour_in     = hour_ff;
      in_ready    = 1'b0;
      q_push      = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               tick_in  = in_tick;
               code_in  = in_code;
               bid_in   = in_bid;
               ask_in   = in_ask;
               bsz_in   = in_bid_size;
               asz_in   = in_ask_size;
               state_in = F_EST;
            end
         end
         F_EST: begin
            // estimate quotients, classify and latch the quote
            mins_in    = MINS_W'(mins_prod >> RECIP_SH);
            hour_in    = HOUR_W'(hour_prod >> RECIP_SH);
            changed_in = 1'b0;
            if (!tick_ff) begin
               kind_in = TK_NONE;
            end else if (!seen_ff) begin
               kind_in     = TK_FIRST;
               seen_in     = 1'b1;
               prev_bid_in = bid_ff;
               prev_ask_in = ask_ff;
               prev_bsz_in = bsz_ff;
               prev_asz_in = asz_ff;
            end else begin
               kind_in    = TK_NEXT;
               changed_in = quote_diff;
               if (quote_diff) begin
                  prev_bid_in = bid_ff;
                  prev_ask_in = ask_ff;
                  prev_bsz_in = bsz_ff;
                  prev_asz_in = asz_ff;
               end
            end
            state_in = F_FIX;
         end
         F_FIX: begin
            // estimates may be one low
            if (mins_rem >= TC_W'(MINS_DIV)) begin
               mins_in = mins_ff + MINS_W'(1);
            end
            if (hour_rem >= TC_W'(HOUR_DIV)) begin
               hour_in = hour_ff + HOUR_W'(1);
            end
            state_in = F_CONV;
         end
         F_CONV: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         seen_ff     <= 1'b0;
         prev_bid_ff <= '0;
         prev_ask_ff <= '0;
         prev_bsz_ff <= '0;
         prev_asz_ff <= '0;
      end else begin
         state_ff    <= state_in;
         seen_ff     <= seen_in;
         prev_bid_ff <= prev_bid_in;
         prev_ask_ff <= prev_ask_in;
         prev_bsz_ff <= prev_bsz_in;
         prev_asz_ff <= prev_asz_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      tick_ff    <= tick_in;
      code_ff    <= code_in;
      bid_ff     <= bid_in;
      ask_ff     <= ask_in;
      bsz_ff     <= bsz_in;
      asz_ff     <= asz_in;
      kind_ff    <= kind_in;
      changed_ff <= changed_in;
      mins_ff    <= mins_in;
      hour_ff    <= hour_in;
   end

endmodule

`default_nettype wire

/* rtl/qurw_queue.sv */
// Short FIFO of classified ticks between front end and back end.
// Uses qurw_pkg for the entry type and depth.
`default_nettype none

module qurw_queue
   import qurw_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type din,
   input  wire logic      pop,
   output entry_type      dout,
   output logic           full,
   output logic           empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

/* rtl/qurw_log.sv */
// Iterative ln(1+count) unit: normalize, 32 squaring steps for log2, then
// scale by ln 2 and round to FRAC_BITS. One shared 32x32 multiplier. Uses qurw_pkg.
`default_nettype none

module qurw_log
   import qurw_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire log_req_type req,
   output log_rsp_type      rsp
);

   localparam int RND_SH = VALUE_W - FRAC_BITS;

   log_state_type        state_ff, state_in;
   logic [MANT_W-1:0]    m_ff, m_in;
   logic [EXP_W-1:0]     e_ff, e_in;
   logic [MANT_W-1:0]    frac_ff, frac_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [MANT_W-1:0]    plo_ff, plo_in;
   logic [LOG_T_W-1:0]   t_ff, t_in;

   logic [MANT_W-1:0]    mul_a;
   logic [MANT_W-1:0]    mul_b;
   logic [2*MANT_W-1:0]  prod;
   logic [MANT_W:0]      sq;
   logic [STEP_W-1:0]    norm_sh;
   logic                 top_zero;
   logic [LOG_T_W-1:0]   rounded;

   // Shared multiplier
   assign prod     = (2*MANT_W)'(mul_a) * (2*MANT_W)'(mul_b);
   assign sq       = prod[2*MANT_W-1:MANT_W-1];
   assign norm_sh  = STEP_W'(NORM_FIRST >> step_ff);
   assign top_zero = ((m_ff >> (MANT_W - int'(norm_sh))) == '0);
   assign rounded  = t_ff + (LOG_T_W'(1) << (RND_SH - 1));

   always_comb begin
      state_in  = state_ff;
      m_in      = m_ff;
      e_in      = e_ff;
      frac_in   = frac_ff;
      step_in   = step_ff;
      plo_in    = plo_ff;
      t_in      = t_ff;
      mul_a     = m_ff;
      mul_b     = m_ff;
      rsp.done  = 1'b0;
      rsp.value = VALUE_W'(rounded >> RND_SH);
      unique case (state_ff)
         L_IDLE: begin
            if (req.start) begin
               frac_in = '0;
               step_in = '0;
               if (req.count == '1) begin
                  // 1+count is exactly 2^32
                  m_in     = MANT_W'(1) << (MANT_W - 1);
                  e_in     = EXP_W'(MANT_W);
                  state_in = L_SQR;
               end else begin
                  m_in     = req.count + MANT_W'(1);
                  e_in     = EXP_W'(MANT_W - 1);
                  state_in = L_NORM;
               end
            end
         end
         L_NORM: begin
            // shift left by 16, 8, 4, 2, 1 while the top bits are clear
            if (top_zero) begin
               m_in = m_ff << norm_sh;
               e_in = e_ff - EXP_W'(norm_sh);
            end
            if (step_ff == STEP_W'(NORM_STEPS - 1)) begin
               step_in  = '0;
               state_in = L_SQR;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         L_SQR: begin
            // one fraction bit of log2 per square
            frac_in = {frac_ff[MANT_W-2:0], sq[MANT_W]};
            m_in    = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
            if (step_ff == STEP_W'(MANT_W - 1)) begin
               state_in = L_MLO;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         L_MLO: begin
            mul_a    = MANT_W'(frac_ff[15:0]);
            mul_b    = LN2_Q32;
            plo_in   = prod[47:16];
            state_in = L_MHI;
         end
         L_MHI: begin
            mul_a    = MANT_W'({e_ff, frac_ff[MANT_W-1:16]});
            mul_b    = LN2_Q32;
            t_in     = LOG_T_W'(prod) + LOG_T_W'(plo_ff);
            state_in = L_RND;
         end
         L_RND: begin
            rsp.done = 1'b1;
            state_in = L_IDLE;
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      e_ff    <= e_in;
      frac_ff <= frac_in;
      plo_ff  <= plo_in;
      t_ff    <= t_in;
   end

endmodule

`default_nettype wire

/* rtl/qurw_back.sv */
// Back end: window bookkeeping, change count, held value and the result
// register. Drives qurw_log for closures with log normalization. Uses qurw_pkg.
`default_nettype none

module qurw_back
   import qurw_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [WLEN_W-1:0]   window_len,
   input  wire logic                log_norm,
   input  wire logic                q_empty,
   input  wire entry_type           q_entry,
   output logic                     q_pop,
   output log_req_type              log_req,
   input  wire log_rsp_type         log_rsp,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [VALUE_W-1:0]       out_value,
   output logic                     out_closed
);

   back_state_type         state_ff, state_in;
   logic [MS_W-1:0]        begin_ff, begin_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [VALUE_W-1:0]     held_ff, held_in;
   logic                   closed_ff, closed_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                   rsp_closed_ff, rsp_closed_in;

   logic [COUNT_W-1:0]     count_upd;
   logic [MS_W-1:0]        elapsed;
   logic [RAW_W-1:0]       raw_wide;
   logic [VALUE_W-1:0]     raw_value;

   assign count_upd = (q_entry.changed && (count_ff != '1)) ? count_ff + COUNT_W'(1)
                                                             : count_ff;
   assign elapsed   = q_entry.now_ms - begin_ff;
   assign raw_wide  = RAW_W'(count_upd) << FRAC_BITS;
   assign raw_value = (|raw_wide[RAW_W-1:VALUE_W]) ? '1 : raw_wide[VALUE_W-1:0];

   assign out_valid  = rsp_valid_ff;
   assign out_value  = rsp_value_ff;
   assign out_closed = rsp_closed_ff;

   always_comb begin
      state_in      = state_ff;
      begin_in      = begin_ff;
      count_in      = count_ff;
      held_in       = held_ff;
      closed_in     = closed_ff;
      rsp_valid_in  = rsp_valid_ff && !out_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_closed_in = rsp_closed_ff;
      q_pop         = 1'b0;
      log_req.start = 1'b0;
      log_req.count = count_upd;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               closed_in = 1'b0;
               state_in  = B_OUT;
               case (q_entry.kind)
                  TK_FIRST: begin
                     begin_in = q_entry.now_ms;
                  end
                  TK_NEXT: begin
                     if (q_entry.now_ms < begin_ff) begin
                        // time ran backwards: restart the window
                        begin_in = q_entry.now_ms;
                        count_in = '0;
                     end else if (WLEN_W'(elapsed) >= window_len) begin
                        // close the window and publish
                        begin_in  = q_entry.now_ms;
                        count_in  = '0;
                        closed_in = 1'b1;
                        if (log_norm && (elapsed != '0)) begin
                           log_req.start = 1'b1;
                           state_in      = B_LOG;
                        end else begin
                           held_in = raw_value;
                        end
                     end else begin
                        count_in = count_upd;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         B_LOG: begin
            if (log_rsp.done) begin
               held_in  = log_rsp.value;
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            // load the result register once it is free
            if (!rsp_valid_ff || out_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = held_ff;
               rsp_closed_in = closed_ff;
               state_in      = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         begin_ff     <= '0;
         count_ff     <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         begin_ff     <= begin_in;
         count_ff     <= count_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      closed_ff     <= closed_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_closed_ff <= rsp_closed_in;
   end

endmodule

`default_nettype wire

/* rtl/quote_update_rate_window_unit.sv */
// Top level of the quote update rate window unit: configuration registers,
// front end, queue, back end and log unit. Uses qurw_pkg and all qurw_ modules.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_tvalid/req_tready  tdata: ticks, tuser: tick_present
//   rsp_      out        rsp_tvalid/rsp_tready  tdata: factor_value, tuser: closed
//   csr_      in         csr_we                 csr_index, csr_wdata
//
// The front end takes a new word only after the last one has passed its accept,
// estimate, correct and queue states; it waits in queue while the queue is full.
// A window closure with log normalization runs 5 normalize steps and 32 squaring
// steps on the shared 32x32 multiplier, then scaling by ln 2 and rounding.
// Reset is synchronous and needs no clearing pass. A two-word queue lets the
// front end keep taking words while the back end or rsp_tready stalls.
`default_nettype none

module quote_update_rate_window_unit
   import qurw_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request stream
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // [29:0] clock_time_code, [93:30] bid_price_bits, [157:94] ask_price_bits,
   // [189:158] bid_size, [221:190] ask_size, [223:222] zero
   input  wire logic [REQ_DATA_W-1:0]   req_tdata,
   // [0] tick_present
   input  wire logic [0:0]              req_tuser,
   // result stream
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // [47:0] factor_value
   output logic [RSP_DATA_W-1:0]        rsp_tdata,
   // [0] window_closed
   output logic [0:0]                   rsp_tuser,
   // configuration
   input  wire logic                    csr_we,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int BID_LO  = TIME_CODE_W;
   localparam int ASK_LO  = BID_LO + PRICE_W;
   localparam int BSZ_LO  = ASK_LO + PRICE_W;
   localparam int ASZ_LO  = BSZ_LO + SIZE_W;

   logic [WLEN_W-1:0]  window_len_ff, window_len_in;
   logic               log_norm_ff, log_norm_in;

   logic               q_full;
   logic               q_empty;
   logic               q_push;
   logic               q_pop;
   entry_type          push_entry;
   entry_type          head_entry;
   log_req_type        log_req;
   log_rsp_type        log_rsp;
   logic [VALUE_W-1:0] factor_value;
   logic               window_closed;

   // Register writes
   always_comb begin
      window_len_in = window_len_ff;
      log_norm_in   = log_norm_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_LEN: window_len_in = csr_wdata[WLEN_W-1:0];
            CSR_LOG_NORM:   log_norm_in   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WINDOW_RESET;
         log_norm_ff   <= 1'b1;
      end else begin
         window_len_ff <= window_len_in;
         log_norm_ff   <= log_norm_in;
      end
   end

   qurw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_tick     (req_tuser[0]),
      .in_code     (req_tdata[TIME_CODE_W-1:0]),
      .in_bid      (req_tdata[BID_LO +: PRICE_W]),
      .in_ask      (req_tdata[ASK_LO +: PRICE_W]),
      .in_bid_size (req_tdata[BSZ_LO +: SIZE_W]),
      .in_ask_size (req_tdata[ASZ_LO +: SIZE_W]),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (push_entry)
   );

   qurw_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (push_entry),
      .pop   (q_pop),
      .dout  (head_entry),
      .full  (q_full),
      .empty (q_empty)
   );

   qurw_log #(
      .FRAC_BITS (FRAC_BITS)
   ) u_log (
      .clock (clock),
      .reset (reset),
      .req   (log_req),
      .rsp   (log_rsp)
   );

   qurw_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .window_len (window_len_ff),
      .log_norm   (log_norm_ff),
      .q_empty    (q_empty),
      .q_entry    (head_entry),
      .q_pop      (q_pop),
      .log_req    (log_req),
      .log_rsp    (log_rsp),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_value  (factor_value),
      .out_closed (window_closed)
   );

   assign rsp_tdata    = RSP_DATA_W'(factor_value);
   assign rsp_tuser[0] = window_closed;

endmodule

`default_nettype wire
